>>> design/uvs_pkg.sv
// ----------------------------------------------------------------------------
// UV sphere point generator package
// Shared widths, fixed-point constants, register codes and payload types.
// ----------------------------------------------------------------------------
package uvs_pkg;

	// Grid limits and field widths.
	localparam int MAX_GRID  = 1024;
	localparam int CNT_W     = 11;
	localparam int IDX_W     = 10;
	localparam int DEN_W     = 10;
	localparam int TRI_W     = 20;
	localparam int POS_W     = 16;
	localparam int FRAC_BITS = 14;

	// Angles are 32-bit phases, one full turn is 2^32.
	localparam int PHASE_W = 32;
	localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;

	// The phase divider works on a 42-bit dividend, six quotient bits per stage.
	localparam int DVD_W      = 42;
	localparam int DIV_STEPS  = 6;
	localparam int DIV_STAGES = DVD_W / DIV_STEPS;

	// Q30 magnitudes and the odd Taylor coefficients of sin(pi/2*t).
	localparam int MAG_W = 31;
	localparam int POLY_W = 32;
	localparam logic [MAG_W-1:0] Q30_ONE = 31'h4000_0000;
	localparam logic [POLY_W-1:0] C1 = 32'd1686629713;
	localparam logic [POLY_W-1:0] C3 = 32'd693598668;
	localparam logic [POLY_W-1:0] C5 = 32'd85569306;
	localparam logic [POLY_W-1:0] C7 = 32'd5026995;
	localparam logic [POLY_W-1:0] C9 = 32'd172272;

	// Configuration register codes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_RING_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECTOR_COUNT = 2'd1;

	typedef struct packed {
		logic [IDX_W-1:0] ring_index;
		logic [IDX_W-1:0] sector_index;
	} point_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic [TRI_W-1:0] tri_a0;
		logic [TRI_W-1:0] tri_a1;
		logic [TRI_W-1:0] tri_a2;
		logic [TRI_W-1:0] tri_b0;
		logic [TRI_W-1:0] tri_b1;
		logic [TRI_W-1:0] tri_b2;
		logic quad_valid;
		logic point_in_range;
	} result_t;

	// What the phase divider hands on to the rest of the pipeline.
	typedef struct packed {
		logic valid;
		point_t pt;
		logic [PHASE_W-1:0] pol_phase;
		logic [PHASE_W-1:0] az_phase;
	} div_res_t;

endpackage

>>> design/uvs_phase_div.sv
// ----------------------------------------------------------------------------
// UV sphere phase divider
// Pipelined restoring division that turns ring and sector indices into
// rounded polar and azimuth phases.
// ----------------------------------------------------------------------------
module uvs_phase_div import uvs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  logic             in_valid,
	input  point_t           pt,
	input  logic [DEN_W-1:0] ring_den,
	input  logic [DEN_W-1:0] sector_den,
	output div_res_t         res
);

	typedef struct packed {
		logic [DEN_W-1:0]   rem;
		logic [DVD_W-1:0]   dvd;
		logic [PHASE_W-1:0] q;
	} div_st_t;

	// Six restoring steps; the quotient keeps only its low 32 bits.
	function automatic div_st_t div_steps(div_st_t st, logic [DEN_W-1:0] den);
		div_st_t x;
		logic [DEN_W:0] cur;
		x = st;
		for (int i = 0; i < DIV_STEPS; i++) begin
			cur = {x.rem, x.dvd[DVD_W-1]};
			x.dvd = {x.dvd[DVD_W-2:0], 1'b0};
			if (cur >= {1'b0, den}) begin
				x.rem = DEN_W'(cur - {1'b0, den});
				x.q = {x.q[PHASE_W-2:0], 1'b1};
			end else begin
				x.rem = cur[DEN_W-1:0];
				x.q = {x.q[PHASE_W-2:0], 1'b0};
			end
		end
		return x;
	endfunction

	logic    vld_s [0:DIV_STAGES];
	point_t  pt_s  [0:DIV_STAGES];
	div_st_t pol_s [0:DIV_STAGES];
	div_st_t az_s  [0:DIV_STAGES];

	// Entry stage: dividend is index scaled to a half or full turn, plus half
	// the divisor so that the truncating divide rounds half up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s[0] <= pt;
			pol_s[0].rem <= '0;
			pol_s[0].q <= '0;
			pol_s[0].dvd <= DVD_W'({pt.ring_index, 31'b0}) + DVD_W'(ring_den >> 1);
			az_s[0].rem <= '0;
			az_s[0].q <= '0;
			az_s[0].dvd <= {pt.sector_index, 32'b0} + DVD_W'(sector_den >> 1);
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pt_s[k+1] <= pt_s[k];
				pol_s[k+1] <= div_steps(pol_s[k], ring_den);
				az_s[k+1] <= div_steps(az_s[k], sector_den);
			end
		end
	end

	assign res.valid = vld_s[DIV_STAGES];
	assign res.pt = pt_s[DIV_STAGES];
	assign res.pol_phase = pol_s[DIV_STAGES].q;
	assign res.az_phase = az_s[DIV_STAGES].q;

endmodule

>>> design/uvs_sine.sv
// ----------------------------------------------------------------------------
// UV sphere sine unit
// Six-stage pipelined quarter-wave sine of a 32-bit phase, one multiply
// per stage, giving a Q30 magnitude and a sign.
// ----------------------------------------------------------------------------
module uvs_sine import uvs_pkg::*; (
	input  logic               clk,
	input  logic               adv,
	input  logic [PHASE_W-1:0] phase,
	output logic [MAG_W-1:0]   mag,
	output logic               neg
);

	logic [MAG_W-1:0]  t_c;
	logic [MAG_W-1:0]  t_s1, t_s2, t_s3, t_s4, t_s5;
	logic [MAG_W-1:0]  t2_s1, t2_s2, t2_s3, t2_s4;
	logic [POLY_W-1:0] p_s2, p_s3, p_s4, p_s5;
	logic              neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [MAG_W-1:0]  mag_s6;
	logic [2*MAG_W-1:0] sq_c;
	logic [MAG_W+POLY_W-1:0] m2_c, m3_c, m4_c, m5_c, m6_c;
	logic [POLY_W:0]   fin_c;

	// Odd quadrants run the wave backwards from the quarter point.
	always_comb begin
		if (phase[30]) begin
			t_c = Q30_ONE - MAG_W'(phase[29:0]);
		end else begin
			t_c = MAG_W'(phase[29:0]);
		end
		sq_c = t_c * t_c;
		m2_c = t2_s1 * C9;
		m3_c = t2_s2 * p_s2;
		m4_c = t2_s3 * p_s3;
		m5_c = t2_s4 * p_s4;
		m6_c = t_s5 * p_s5;
		fin_c = m6_c[30 +: POLY_W+1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= t_c;
			t2_s1 <= sq_c[30 +: MAG_W];
			neg_s1 <= phase[31];

			t_s2 <= t_s1;
			t2_s2 <= t2_s1;
			p_s2 <= C7 - m2_c[30 +: POLY_W];
			neg_s2 <= neg_s1;

			t_s3 <= t_s2;
			t2_s3 <= t2_s2;
			p_s3 <= C5 - m3_c[30 +: POLY_W];
			neg_s3 <= neg_s2;

			t_s4 <= t_s3;
			t2_s4 <= t2_s3;
			p_s4 <= C3 - m4_c[30 +: POLY_W];
			neg_s4 <= neg_s3;

			t_s5 <= t_s4;
			p_s5 <= C1 - m5_c[30 +: POLY_W];
			neg_s5 <= neg_s4;

			mag_s6 <= (fin_c > (POLY_W+1)'(Q30_ONE)) ? Q30_ONE : fin_c[MAG_W-1:0];
			neg_s6 <= neg_s5;
		end
	end

	assign mag = mag_s6;
	assign neg = neg_s6;

endmodule

>>> design/uv_sphere_point_generator.sv
// ----------------------------------------------------------------------------
// UV sphere point generator
// Maps a grid point to its unit-sphere vertex and the two triangles of its
// grid quad.
// ----------------------------------------------------------------------------
// A request on the point channel carries one ring and one sector index; for
// every accepted request the block returns exactly one result, in order,
// holding the vertex in signed Q1.14 and the six corner indices of the quad
// whose lower corner is that point. The block accepts one request per clock
// while the result is not stalled. A request passes through the phase
// divider (an entry stage and seven stages of six quotient bits each), the
// sine units (one multiply per stage), and the output register that forms
// the final products. When the result is stalled the whole pipeline holds,
// so point_stall follows result_stall while a result waits. Ring and sector
// counts are written through the configuration channel, which is always
// ready; counts above 1024 saturate.
// Write them only while no request is in flight.
module uv_sphere_point_generator import uvs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 point_valid,
	output logic                 point_stall,
	input  point_t               point,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]     cfg_data
);

	localparam int SINE_STAGES = 6;
	localparam int XZ_SHIFT = 60 - FRAC_BITS;
	localparam int Y_SHIFT = 30 - FRAC_BITS;

	typedef struct packed {
		logic quad;
		logic inr;
		logic [TRI_W-1:0] lo;
		logic [TRI_W-1:0] hi;
	} side_t;

	// Product of two Q30 magnitudes, rounded half away from zero, clamped to
	// one, and then given its sign.
	function automatic logic [POS_W-1:0] to_pos(logic [MAG_W-1:0] a,
			logic [MAG_W-1:0] b, logic neg);
		logic [2*MAG_W-1:0] prod;
		logic [2*MAG_W-1:0] rnd;
		logic [POS_W:0] m;
		prod = a * b;
		rnd = prod + ((2*MAG_W)'(1) << (XZ_SHIFT - 1));
		m = (POS_W+1)'(rnd >> XZ_SHIFT);
		if (m > ((POS_W+1)'(1) << FRAC_BITS)) begin
			m = (POS_W+1)'(1) << FRAC_BITS;
		end
		if (neg) begin
			m = -m;
		end
		return m[POS_W-1:0];
	endfunction

	logic [CNT_W-1:0] ring_count_q, sector_count_q;
	logic [DEN_W-1:0] ring_den, sector_den;
	logic adv;
	div_res_t div_res;
	logic [MAG_W-1:0] sp_mag, cp_mag, sa_mag, ca_mag;
	logic sp_neg, cp_neg, sa_neg, ca_neg;
	logic vld_s [1:SINE_STAGES];
	side_t side_s [1:SINE_STAGES];
	side_t side_c;
	logic [2*IDX_W:0] lo_c;
	logic [CNT_W-1:0] cfg_val;
	logic [MAG_W:0] y_rnd;
	logic [POS_W:0] y_m;
	logic out_vld_q;
	result_t out_q;

	// Configuration: saturate to the largest grid, ignore unknown codes.
	assign cfg_ready = 1'b1;
	assign cfg_val = (cfg_data > CNT_W'(MAX_GRID)) ? CNT_W'(MAX_GRID) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_count_q <= CNT_W'(16);
			sector_count_q <= CNT_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RING_COUNT: ring_count_q <= cfg_val;
				REG_SECTOR_COUNT: sector_count_q <= cfg_val;
				default: ;
			endcase
		end
	end

	// Divisors are count minus one, taken as one for counts below two.
	assign ring_den = (ring_count_q >= CNT_W'(2)) ? DEN_W'(ring_count_q - CNT_W'(1)) : DEN_W'(1);
	assign sector_den = (sector_count_q >= CNT_W'(2)) ?
		DEN_W'(sector_count_q - CNT_W'(1)) : DEN_W'(1);

	// The whole pipeline moves together unless a finished result is stalled.
	assign adv = !out_vld_q || !result_stall;
	assign point_stall = !adv;

	uvs_phase_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (point_valid),
		.pt         (point),
		.ring_den   (ring_den),
		.sector_den (sector_den),
		.res        (div_res)
	);

	// Sine and cosine of both angles; cosine is the sine a quarter turn on.
	uvs_sine u_sin_pol (
		.clk(clk), .adv(adv), .phase(div_res.pol_phase), .mag(sp_mag), .neg(sp_neg)
	);
	uvs_sine u_cos_pol (
		.clk(clk), .adv(adv), .phase(div_res.pol_phase + QUARTER_TURN),
		.mag(cp_mag), .neg(cp_neg)
	);
	uvs_sine u_sin_az (
		.clk(clk), .adv(adv), .phase(div_res.az_phase), .mag(sa_mag), .neg(sa_neg)
	);
	uvs_sine u_cos_az (
		.clk(clk), .adv(adv), .phase(div_res.az_phase + QUARTER_TURN),
		.mag(ca_mag), .neg(ca_neg)
	);

	// Grid flags and the quad's base indices, which then ride alongside the
	// sine units. The upper row index is the base plus one row of sectors.
	always_comb begin
		lo_c = (2*IDX_W+1)'(div_res.pt.ring_index) * (2*IDX_W+1)'(sector_count_q)
			+ (2*IDX_W+1)'(div_res.pt.sector_index);
		side_c.quad = (CNT_W'(div_res.pt.ring_index) + CNT_W'(1) < ring_count_q) &&
			(CNT_W'(div_res.pt.sector_index) + CNT_W'(1) < sector_count_q);
		side_c.inr = (CNT_W'(div_res.pt.ring_index) < ring_count_q) &&
			(CNT_W'(div_res.pt.sector_index) < sector_count_q);
		side_c.lo = lo_c[TRI_W-1:0];
		side_c.hi = lo_c[TRI_W-1:0] + TRI_W'(sector_count_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= SINE_STAGES; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= div_res.valid;
			for (int i = 2; i <= SINE_STAGES; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[1] <= side_c;
			for (int i = 2; i <= SINE_STAGES; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// The vertical coordinate is minus the polar cosine times one, so it only needs
	// rounding to the output precision.
	always_comb begin
		y_rnd = (MAG_W+1)'(cp_mag) + ((MAG_W+1)'(1) << (Y_SHIFT - 1));
		y_m = (POS_W+1)'(y_rnd >> Y_SHIFT);
		if (y_m > ((POS_W+1)'(1) << FRAC_BITS)) begin
			y_m = (POS_W+1)'(1) << FRAC_BITS;
		end
		if (!cp_neg) begin
			y_m = -y_m;
		end
	end

	// Output register: final products, and triangles zeroed off the grid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s[SINE_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.pos_x <= to_pos(ca_mag, sp_mag, ca_neg ^ sp_neg);
			out_q.pos_y <= y_m[POS_W-1:0];
			out_q.pos_z <= to_pos(sa_mag, sp_mag, sa_neg ^ sp_neg);
			out_q.quad_valid <= side_s[SINE_STAGES].quad;
			out_q.point_in_range <= side_s[SINE_STAGES].inr;
			if (side_s[SINE_STAGES].quad) begin
				out_q.tri_a0 <= side_s[SINE_STAGES].lo;
				out_q.tri_a1 <= side_s[SINE_STAGES].hi;
				out_q.tri_a2 <= side_s[SINE_STAGES].hi + TRI_W'(1);
				out_q.tri_b0 <= side_s[SINE_STAGES].lo;
				out_q.tri_b1 <= side_s[SINE_STAGES].hi + TRI_W'(1);
				out_q.tri_b2 <= side_s[SINE_STAGES].lo + TRI_W'(1);
			end else begin
				out_q.tri_a0 <= '0;
				out_q.tri_a1 <= '0;
				out_q.tri_a2 <= '0;
				out_q.tri_b0 <= '0;
				out_q.tri_b1 <= '0;
				out_q.tri_b2 <= '0;
			end
		end
	end

	assign result_valid = out_vld_q;
	assign result = out_q;

`ifndef ASSERT_OFF
	// A point with a valid quad always lies inside the grid.
	a_quad_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.quad_valid |-> result.point_in_range)
		else $error("quad flagged valid for a point outside the grid");

	// Triangles off the grid are all zero.
	a_tri_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.quad_valid |-> (result.tri_a0 == '0) &&
		(result.tri_a1 == '0) && (result.tri_a2 == '0) && (result.tri_b0 == '0) &&
		(result.tri_b1 == '0) && (result.tri_b2 == '0))
		else $error("triangle indices not cleared for an invalid quad");

	// The vertex never leaves the unit range.
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($signed(result.pos_x) >= -16'sd16384) &&
		($signed(result.pos_x) <= 16'sd16384) && ($signed(result.pos_y) >= -16'sd16384) &&
		($signed(result.pos_y) <= 16'sd16384) && ($signed(result.pos_z) >= -16'sd16384) &&
		($signed(result.pos_z) <= 16'sd16384))
		else $error("vertex coordinate outside the unit range");

	// Saturation keeps both counts within the largest grid.
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(ring_count_q <= CNT_W'(MAX_GRID)) && (sector_count_q <= CNT_W'(MAX_GRID)))
		else $error("grid count above the maximum");
`endif

endmodule
